// ===== rtl/core/pve_pkg.sv =====
`timescale 1ns / 1ps

package pve_pkg;

   localparam int COORD_W    = 20;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int COEFF_W    = 32;
   localparam int CUTOFF_W   = 20;
   localparam int SQ_W       = 2 * COORD_W;
   localparam int D2_W       = SQ_W + 2;
   localparam int QUOT_W     = 53;
   localparam int OPND_W     = 64;
   localparam int HALF_W     = OPND_W / 2;
   localparam int ACC_W      = 2 * OPND_W;
   localparam int ENERGY_W   = 48;
   localparam int TERM_W     = ENERGY_W + 2;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 20'd512;
   localparam logic CSR_IDX_MIN_DIST = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_Z,
      ST_CUT,
      ST_CHECK,
      ST_DIV,
      ST_R2,
      ST_R3,
      ST_R6,
      ST_REP,
      ST_ATT,
      ST_TERM,
      ST_ACCUM,
      ST_FINISH
   } seq_state_type;

   typedef enum logic [1:0] {
      MUL_IDLE,
      MUL_ISSUE,
      MUL_LAST,
      MUL_DONE
   } mul_state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   typedef enum logic [1:0] {
      SHIFT_0,
      SHIFT_24,
      SHIFT_32
   } mul_shift_type;

   typedef struct packed {
      logic          start;
      mul_shift_type shift;
   } mul_cmd_type;

   typedef struct packed {
      logic idle;
      logic done;
   } unit_status_type;

endpackage

// ===== rtl/core/pve_mul.sv =====
`timescale 1ns / 1ps

module pve_mul (
   input  logic                              clock,
   input  logic                              reset,
   input  pve_pkg::mul_cmd_type              cmd,
   input  logic [pve_pkg::OPND_W-1:0]        op_a,
   input  logic [pve_pkg::OPND_W-1:0]        op_b,
   output pve_pkg::unit_status_type          status,
   output logic [pve_pkg::OPND_W-1:0]        result
);

   localparam int OW = pve_pkg::OPND_W;
   localparam int HW = pve_pkg::HALF_W;
   localparam int AW = pve_pkg::ACC_W;

   pve_pkg::mul_state_type state_ff, state_in;
   pve_pkg::mul_shift_type shift_ff, shift_in;
   logic [OW-1:0] a_ff, a_in, b_ff, b_in;
   logic [1:0]    step_ff, step_in;
   logic [OW-1:0] prod_ff, prod_in;
   logic [1:0]    prod_step_ff, prod_step_in;
   logic          prod_valid_ff, prod_valid_in;
   logic [AW-1:0] acc_ff, acc_in;

   logic [HW-1:0] a_half, b_half;
   logic [AW-1:0] addend;
   logic [OW-1:0] res_raw;
   logic          res_sat;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pve_pkg::MUL_IDLE: begin
            if (cmd.start) state_in = pve_pkg::MUL_ISSUE;
         end
         pve_pkg::MUL_ISSUE: begin
            if (step_ff == 2'd3) state_in = pve_pkg::MUL_LAST;
         end
         pve_pkg::MUL_LAST: state_in = pve_pkg::MUL_DONE;
         pve_pkg::MUL_DONE: state_in = pve_pkg::MUL_IDLE;
         default: state_in = pve_pkg::MUL_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      status.idle = (state_ff == pve_pkg::MUL_IDLE);
      status.done = (state_ff == pve_pkg::MUL_DONE);
   end

   // partial products: one 32x32 per cycle
   always_comb begin
      a_half = step_ff[0] ? a_ff[OW-1:HW] : a_ff[HW-1:0];
      b_half = step_ff[1] ? b_ff[OW-1:HW] : b_ff[HW-1:0];
      case (prod_step_ff)
         2'b00:   addend = {{OW{1'b0}}, prod_ff};
         2'b11:   addend = {prod_ff, {OW{1'b0}}};
         default: addend = {{HW{1'b0}}, prod_ff, {HW{1'b0}}};
      endcase
   end

   always_comb begin
      a_in          = a_ff;
      b_in          = b_ff;
      shift_in      = shift_ff;
      step_in       = step_ff;
      acc_in        = acc_ff;
      prod_in       = a_half * b_half;
      prod_step_in  = step_ff;
      prod_valid_in = (state_ff == pve_pkg::MUL_ISSUE);
      if (prod_valid_ff) acc_in = acc_ff + addend;
      case (state_ff)
         pve_pkg::MUL_IDLE: begin
            if (cmd.start) begin
               a_in     = op_a;
               b_in     = op_b;
               shift_in = cmd.shift;
               step_in  = 2'd0;
               acc_in   = '0;
            end
         end
         pve_pkg::MUL_ISSUE: step_in = step_ff + 2'd1;
         default: ;
      endcase
   end

   // truncating shift with saturation to all ones
   always_comb begin
      case (shift_ff)
         pve_pkg::SHIFT_24: begin
            res_sat = |acc_ff[AW-1:OW+24];
            res_raw = acc_ff[OW+23:24];
         end
         pve_pkg::SHIFT_32: begin
            res_sat = |acc_ff[AW-1:OW+32];
            res_raw = acc_ff[OW+31:32];
         end
         default: begin
            res_sat = |acc_ff[AW-1:OW];
            res_raw = acc_ff[OW-1:0];
         end
      endcase
      result = res_sat ? {OW{1'b1}} : res_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pve_pkg::MUL_IDLE;
         step_ff       <= 2'd0;
         prod_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         prod_valid_ff <= prod_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      b_ff         <= b_in;
      shift_ff     <= shift_in;
      prod_ff      <= prod_in;
      prod_step_ff <= prod_step_in;
      acc_ff       <= acc_in;
   end

endmodule

// ===== rtl/core/pve_div.sv =====
`timescale 1ns / 1ps

module pve_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [pve_pkg::D2_W-1:0]        divisor,
   output pve_pkg::unit_status_type        status,
   output logic [pve_pkg::QUOT_W-1:0]      quotient
);

   localparam int DW = pve_pkg::D2_W;
   localparam int QW = pve_pkg::QUOT_W;
   localparam int CW = $clog2(QW);
   localparam logic [CW-1:0] TOP_BIT = CW'(QW - 1);

   pve_pkg::div_state_type state_ff, state_in;
   logic [CW-1:0] bit_idx_ff, bit_idx_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [QW-1:0] quot_ff, quot_in;
   logic [DW-1:0] div_ff, div_in;

   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          ge;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pve_pkg::DIV_IDLE: begin
            if (start) state_in = pve_pkg::DIV_RUN;
         end
         pve_pkg::DIV_RUN: begin
            if (bit_idx_ff == '0) state_in = pve_pkg::DIV_DONE;
         end
         pve_pkg::DIV_DONE: state_in = pve_pkg::DIV_IDLE;
         default: state_in = pve_pkg::DIV_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      status.idle = (state_ff == pve_pkg::DIV_IDLE);
      status.done = (state_ff == pve_pkg::DIV_DONE);
      quotient    = quot_ff;
   end

   // restoring radix-2, dividend is a single one at the top quotient bit
   always_comb begin
      trial      = {rem_ff, (bit_idx_ff == TOP_BIT)};
      diff       = trial - {1'b0, div_ff};
      ge         = (trial >= {1'b0, div_ff});
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      bit_idx_in = bit_idx_ff;
      div_in     = div_ff;
      case (state_ff)
         pve_pkg::DIV_IDLE: begin
            if (start) begin
               rem_in     = '0;
               quot_in    = '0;
               bit_idx_in = TOP_BIT;
               div_in     = divisor;
            end
         end
         pve_pkg::DIV_RUN: begin
            rem_in     = ge ? diff[DW-1:0] : trial[DW-1:0];
            quot_in    = {quot_ff[QW-2:0], ge};
            bit_idx_in = bit_idx_ff - CW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= pve_pkg::DIV_IDLE;
         bit_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         bit_idx_ff <= bit_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      div_ff  <= div_in;
   end

endmodule

// ===== rtl/core/pair_vdw_energy_accumulator.sv =====
`timescale 1ns / 1ps

// Lennard-Jones 12-6 pair energy accumulator. Each transfer on req_ is one atom pair; the block
// adds A/d^12 - B/d^6 to a saturating 48-bit sum (16 fractional bits) and, on the pair marked
// last_pair, returns one rsp_ transfer and clears the sum and the sticky too-close flag. A pair
// closer than the cutoff register (offset 0) or at zero distance adds nothing and forces the
// reported energy to the largest value. req_stall is high whenever the sequencer is out of
// idle, so the block takes no new pair until the one before is through, and a pair below the
// cutoff frees it sooner than one in range. Each multiply runs on one shared 32x32 multiplier
// (four partial products; nine multiplies for a pair in range, four below the cutoff), and 1/d2
// comes from a 53-step radix-2 divider. One finished result waits in the output register while
// later pairs are taken; the last pair of the next set holds req_stall until it leaves.
module pair_vdw_energy_accumulator (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [pve_pkg::COORD_W-1:0]   req_first_x,
   input  logic signed [pve_pkg::COORD_W-1:0]   req_first_y,
   input  logic signed [pve_pkg::COORD_W-1:0]   req_first_z,
   input  logic signed [pve_pkg::COORD_W-1:0]   req_second_x,
   input  logic signed [pve_pkg::COORD_W-1:0]   req_second_y,
   input  logic signed [pve_pkg::COORD_W-1:0]   req_second_z,
   input  logic [pve_pkg::COEFF_W-1:0]          req_repulsive_coeff,
   input  logic [pve_pkg::COEFF_W-1:0]          req_attractive_coeff,
   input  logic                                 req_last_pair,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [pve_pkg::ENERGY_W-1:0]  rsp_energy,
   output logic                                 rsp_too_close,

   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pve_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [pve_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [pve_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);

   localparam int CW = pve_pkg::COORD_W;
   localparam int XW = pve_pkg::DIFF_W;
   localparam int KW = pve_pkg::COEFF_W;
   localparam int LW = pve_pkg::CUTOFF_W;
   localparam int SW = pve_pkg::SQ_W;
   localparam int DW = pve_pkg::D2_W;
   localparam int QW = pve_pkg::QUOT_W;
   localparam int OW = pve_pkg::OPND_W;
   localparam int EW = pve_pkg::ENERGY_W;
   localparam int TW = pve_pkg::TERM_W;
   localparam int FW = OW + 1;
   localparam int GW = EW + 3;

   localparam logic signed [FW-1:0] CAP_POS  = FW'(64'sd1 <<< (EW));
   localparam logic signed [FW-1:0] CAP_NEG  = -CAP_POS;
   localparam logic signed [TW-1:0] TERM_POS = TW'(64'sd1 <<< (EW));
   localparam logic signed [TW-1:0] TERM_NEG = -TERM_POS;
   localparam logic signed [EW-1:0] E_MAX    = {1'b0, {(EW-1){1'b1}}};
   localparam logic signed [EW-1:0] E_MIN    = {1'b1, {(EW-1){1'b0}}};

   pve_pkg::seq_state_type state_ff, state_in;

   logic [CW-1:0] x1_ff, y1_ff, z1_ff, x2_ff, y2_ff, z2_ff;
   logic [CW-1:0] x1_in, y1_in, z1_in, x2_in, y2_in, z2_in;
   logic [KW-1:0] coef_a_ff, coef_a_in, coef_b_ff, coef_b_in;
   logic          last_ff, last_in;
   logic [DW-1:0] d2_ff, d2_in;
   logic [SW-1:0] cut2_ff, cut2_in;
   logic [QW-1:0] r_ff, r_in;
   logic [OW-1:0] r2_ff, r2_in, r3_ff, r3_in, r6_ff, r6_in;
   logic [OW-1:0] rep_ff, rep_in, att_ff, att_in;
   logic signed [TW-1:0] term_ff, term_in;
   logic signed [EW-1:0] sum_ff, sum_in;
   logic          close_ff, close_in;
   logic [LW-1:0] cutoff_ff, cutoff_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic signed [EW-1:0] rsp_energy_ff, rsp_energy_in;
   logic          rsp_too_close_ff, rsp_too_close_in;

   pve_pkg::mul_cmd_type     mul_cmd;
   pve_pkg::unit_status_type mul_status;
   pve_pkg::unit_status_type div_status;
   logic [OW-1:0] mul_a, mul_b, mul_result;
   logic          div_start;
   logic [QW-1:0] div_quot;

   logic                 req_xfer;
   logic                 out_free;
   logic                 emit;
   logic [CW-1:0]        pa, pb;
   logic signed [XW-1:0] diff;
   logic [XW-1:0]        mag;
   logic                 is_close;
   logic signed [FW-1:0] rep_diff;
   logic signed [GW-1:0] sum_wide;
   logic                 csr_write;
   logic                 csr_idx;

   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = (state_ff == pve_pkg::ST_FINISH) && last_ff && out_free;
   assign csr_idx   = csr_paddr[pve_pkg::CSR_ADDR_W-1];
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   pve_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mul_cmd),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .status (mul_status),
      .result (mul_result)
   );

   pve_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (d2_ff),
      .status   (div_status),
      .quotient (div_quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pve_pkg::ST_IDLE: begin
            if (req_xfer) state_in = pve_pkg::ST_SQ_X;
         end
         pve_pkg::ST_SQ_X: begin
            if (mul_status.done) state_in = pve_pkg::ST_SQ_Y;
         end
         pve_pkg::ST_SQ_Y: begin
            if (mul_status.done) state_in = pve_pkg::ST_SQ_Z;
         end
         pve_pkg::ST_SQ_Z: begin
            if (mul_status.done) state_in = pve_pkg::ST_CUT;
         end
         pve_pkg::ST_CUT: begin
            if (mul_status.done) state_in = pve_pkg::ST_CHECK;
         end
         pve_pkg::ST_CHECK: begin
            state_in = is_close ? pve_pkg::ST_FINISH : pve_pkg::ST_DIV;
         end
         pve_pkg::ST_DIV: begin
            if (div_status.done) state_in = pve_pkg::ST_R2;
         end
         pve_pkg::ST_R2: begin
            if (mul_status.done) state_in = pve_pkg::ST_R3;
         end
         pve_pkg::ST_R3: begin
            if (mul_status.done) state_in = pve_pkg::ST_R6;
         end
         pve_pkg::ST_R6: begin
            if (mul_status.done) state_in = pve_pkg::ST_REP;
         end
         pve_pkg::ST_REP: begin
            if (mul_status.done) state_in = pve_pkg::ST_ATT;
         end
         pve_pkg::ST_ATT: begin
            if (mul_status.done) state_in = pve_pkg::ST_TERM;
         end
         pve_pkg::ST_TERM:  state_in = pve_pkg::ST_ACCUM;
         pve_pkg::ST_ACCUM: state_in = pve_pkg::ST_FINISH;
         pve_pkg::ST_FINISH: begin
            if (!last_ff || out_free) state_in = pve_pkg::ST_IDLE;
         end
         default: state_in = pve_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall     = (state_ff != pve_pkg::ST_IDLE);
      div_start     = (state_ff == pve_pkg::ST_DIV) && div_status.idle;
      mul_cmd.start = 1'b0;
      mul_cmd.shift = pve_pkg::SHIFT_0;
      mul_a         = '0;
      mul_b         = '0;
      pa            = x1_ff;
      pb            = x2_ff;
      case (state_ff)
         pve_pkg::ST_SQ_Y: begin
            pa = y1_ff;
            pb = y2_ff;
         end
         pve_pkg::ST_SQ_Z: begin
            pa = z1_ff;
            pb = z2_ff;
         end
         default: ;
      endcase
      diff = $signed({pa[CW-1], pa}) - $signed({pb[CW-1], pb});
      mag  = diff[XW-1] ? $unsigned(-diff) : $unsigned(diff);
      case (state_ff)
         pve_pkg::ST_SQ_X, pve_pkg::ST_SQ_Y, pve_pkg::ST_SQ_Z: begin
            mul_cmd.start = mul_status.idle;
            mul_a         = OW'(mag);
            mul_b         = OW'(mag);
         end
         pve_pkg::ST_CUT: begin
            mul_cmd.start = mul_status.idle;
            mul_a         = OW'(cutoff_ff);
            mul_b         = OW'(cutoff_ff);
         end
         pve_pkg::ST_R2: begin
            mul_cmd.start = mul_status.idle;
            mul_cmd.shift = pve_pkg::SHIFT_32;
            mul_a         = OW'(r_ff);
            mul_b         = OW'(r_ff);
         end
         pve_pkg::ST_R3: begin
            mul_cmd.start = mul_status.idle;
            mul_cmd.shift = pve_pkg::SHIFT_32;
            mul_a         = r2_ff;
            mul_b         = OW'(r_ff);
         end
         pve_pkg::ST_R6: begin
            mul_cmd.start = mul_status.idle;
            mul_cmd.shift = pve_pkg::SHIFT_32;
            mul_a         = r3_ff;
            mul_b         = r3_ff;
         end
         pve_pkg::ST_REP: begin
            mul_cmd.start = mul_status.idle;
            mul_cmd.shift = pve_pkg::SHIFT_24;
            mul_a         = OW'(coef_a_ff);
            mul_b         = r6_ff;
         end
         pve_pkg::ST_ATT: begin
            mul_cmd.start = mul_status.idle;
            mul_cmd.shift = pve_pkg::SHIFT_24;
            mul_a         = OW'(coef_b_ff);
            mul_b         = r3_ff;
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      x1_in            = x1_ff;
      y1_in            = y1_ff;
      z1_in            = z1_ff;
      x2_in            = x2_ff;
      y2_in            = y2_ff;
      z2_in            = z2_ff;
      coef_a_in        = coef_a_ff;
      coef_b_in        = coef_b_ff;
      last_in          = last_ff;
      d2_in            = d2_ff;
      cut2_in          = cut2_ff;
      r_in             = r_ff;
      r2_in            = r2_ff;
      r3_in            = r3_ff;
      r6_in            = r6_ff;
      rep_in           = rep_ff;
      att_in           = att_ff;
      term_in          = term_ff;
      sum_in           = sum_ff;
      close_in         = close_ff;
      rsp_energy_in    = rsp_energy_ff;
      rsp_too_close_in = rsp_too_close_ff;

      is_close = (d2_ff == '0) || (d2_ff < DW'(cut2_ff));
      rep_diff = $signed({1'b0, rep_ff}) - $signed({1'b0, att_ff});
      sum_wide = GW'(sum_ff) + GW'(term_ff);

      case (state_ff)
         pve_pkg::ST_IDLE: begin
            if (req_xfer) begin
               x1_in     = req_first_x;
               y1_in     = req_first_y;
               z1_in     = req_first_z;
               x2_in     = req_second_x;
               y2_in     = req_second_y;
               z2_in     = req_second_z;
               coef_a_in = req_repulsive_coeff;
               coef_b_in = req_attractive_coeff;
               last_in   = req_last_pair;
               d2_in     = '0;
            end
         end
         pve_pkg::ST_SQ_X, pve_pkg::ST_SQ_Y, pve_pkg::ST_SQ_Z: begin
            if (mul_status.done) d2_in = d2_ff + DW'(mul_result[SW-1:0]);
         end
         pve_pkg::ST_CUT: begin
            if (mul_status.done) cut2_in = mul_result[SW-1:0];
         end
         pve_pkg::ST_CHECK: begin
            if (is_close) close_in = 1'b1;
         end
         pve_pkg::ST_DIV: begin
            if (div_status.done) r_in = div_quot;
         end
         pve_pkg::ST_R2: begin
            if (mul_status.done) r2_in = mul_result;
         end
         pve_pkg::ST_R3: begin
            if (mul_status.done) r3_in = mul_result;
         end
         pve_pkg::ST_R6: begin
            if (mul_status.done) r6_in = mul_result;
         end
         pve_pkg::ST_REP: begin
            if (mul_status.done) rep_in = mul_result;
         end
         pve_pkg::ST_ATT: begin
            if (mul_status.done) att_in = mul_result;
         end
         pve_pkg::ST_TERM: begin
            // repulsion overflow wins outright
            if (&rep_ff)                 term_in = TERM_POS;
            else if (rep_diff > CAP_POS) term_in = TERM_POS;
            else if (rep_diff < CAP_NEG) term_in = TERM_NEG;
            else                         term_in = TW'(rep_diff);
         end
         pve_pkg::ST_ACCUM: begin
            if (sum_wide[GW-1:EW-1] == '0 || sum_wide[GW-1:EW-1] == '1)
               sum_in = sum_wide[EW-1:0];
            else
               sum_in = sum_wide[GW-1] ? E_MIN : E_MAX;
         end
         pve_pkg::ST_FINISH: begin
            if (emit) begin
               rsp_energy_in    = close_ff ? E_MAX : sum_ff;
               rsp_too_close_in = close_ff;
               sum_in           = '0;
               close_in         = 1'b0;
            end
         end
         default: ;
      endcase

      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
      cutoff_in    = (csr_write && csr_idx == pve_pkg::CSR_IDX_MIN_DIST)
                     ? csr_pwdata[LW-1:0] : cutoff_ff;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_energy    = rsp_energy_ff;
   assign rsp_too_close = rsp_too_close_ff;
   assign csr_pready    = 1'b1;
   assign csr_prdata    = (csr_idx == pve_pkg::CSR_IDX_MIN_DIST)
                          ? pve_pkg::CSR_DATA_W'(cutoff_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pve_pkg::ST_IDLE;
         sum_ff       <= '0;
         close_ff     <= 1'b0;
         cutoff_ff    <= pve_pkg::CUTOFF_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         close_ff     <= close_in;
         cutoff_ff    <= cutoff_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff            <= x1_in;
      y1_ff            <= y1_in;
      z1_ff            <= z1_in;
      x2_ff            <= x2_in;
      y2_ff            <= y2_in;
      z2_ff            <= z2_in;
      coef_a_ff        <= coef_a_in;
      coef_b_ff        <= coef_b_in;
      last_ff          <= last_in;
      d2_ff            <= d2_in;
      cut2_ff          <= cut2_in;
      r_ff             <= r_in;
      r2_ff            <= r2_in;
      r3_ff            <= r3_in;
      r6_ff            <= r6_in;
      rep_ff           <= rep_in;
      att_ff           <= att_in;
      term_ff          <= term_in;
      rsp_energy_ff    <= rsp_energy_in;
      rsp_too_close_ff <= rsp_too_close_in;
   end

endmodule
